// ===== rtl/cka_pkg.sv =====
// Shared types and constants for the chroma key alpha matte block.
package cka_pkg;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CLS_FG  = 2'd0,
        CLS_BG  = 2'd1,
        CLS_DIV = 2'd2
    } t_cls;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_ctl;

    localparam int CfgW    = 16;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_BALANCE      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_RED      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_GREEN    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_BLUE     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BLOCK_WIDTH  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BLOCK_HEIGHT = 3'd5;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [8:0]  BAL_ONE = 9'd256;
    localparam logic [15:0] UNIT_V  = 16'd65280;

    localparam int NumW   = 40;
    localparam int DenW   = 32;
    localparam int AlphaW = 8;

    localparam logic [AlphaW-1:0] ALPHA_FG = 8'd255;
    localparam logic [AlphaW-1:0] ALPHA_BG = 8'd0;

endpackage

// ===== rtl/cka_blkdiv.sv =====
// Pipelined restoring divide of column and line by the grid block size.
module cka_blkdiv #(
    parameter int AW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  cka_pkg::t_ctl   i_ctl,
    input  cka_pkg::t_rgb   i_pix,
    input  logic [15:0]     i_column,
    input  logic [15:0]     i_line,
    input  logic [15:0]     i_bw,
    input  logic [15:0]     i_bh,
    output cka_pkg::t_ctl   o_ctl,
    output cka_pkg::t_rgb   o_pix,
    output logic            o_ovf,
    output logic [AW-1:0]   o_qc,
    output logic [AW-1:0]   o_qr
);
    localparam int DW = 16 + AW;

    cka_pkg::t_ctl r_ctl [AW];
    cka_pkg::t_rgb r_pix [AW];
    logic          r_ovf [AW];
    logic [15:0]   r_rc  [AW];
    logic [15:0]   r_rr  [AW];
    logic [AW-1:0] r_qc  [AW];
    logic [AW-1:0] r_qr  [AW];

    for (genvar s = 0; s < AW; s++) begin : g_st
        localparam int K = AW - 1 - s;
        cka_pkg::t_ctl a_ctl;
        cka_pkg::t_rgb a_pix;
        logic          a_ovf;
        logic [15:0]   a_c;
        logic [15:0]   a_r;
        logic [AW-1:0] a_qc;
        logic [AW-1:0] a_qr;
        logic [DW-1:0] d_c;
        logic [DW-1:0] d_r;
        logic          t_c;
        logic          t_r;

        if (s == 0) begin : g_head
            assign a_ctl = i_ctl;
            assign a_pix = i_pix;
            assign a_c   = i_column;
            assign a_r   = i_line;
            assign a_qc  = '0;
            assign a_qr  = '0;
            assign a_ovf = ({{AW{1'b0}}, i_column} >= {i_bw, {AW{1'b0}}})
                        || ({{AW{1'b0}}, i_line} >= {i_bh, {AW{1'b0}}});
        end else begin : g_body
            assign a_ctl = r_ctl[s-1];
            assign a_pix = r_pix[s-1];
            assign a_c   = r_rc[s-1];
            assign a_r   = r_rr[s-1];
            assign a_qc  = r_qc[s-1];
            assign a_qr  = r_qr[s-1];
            assign a_ovf = r_ovf[s-1];
        end

        assign d_c = {{AW{1'b0}}, i_bw} << K;
        assign d_r = {{AW{1'b0}}, i_bh} << K;
        assign t_c = {{AW{1'b0}}, a_c} >= d_c;
        assign t_r = {{AW{1'b0}}, a_r} >= d_r;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[s] <= a_ctl;
                r_pix[s] <= a_pix;
                r_ovf[s] <= a_ovf;
                r_rc[s]  <= t_c ? (a_c - d_c[15:0]) : a_c;
                r_rr[s]  <= t_r ? (a_r - d_r[15:0]) : a_r;
                r_qc[s]  <= a_qc | (AW'(t_c) << K);
                r_qr[s]  <= a_qr | (AW'(t_r) << K);
            end
        end
    end

    assign o_ctl = r_ctl[AW-1];
    assign o_pix = r_pix[AW-1];
    assign o_ovf = r_ovf[AW-1];
    assign o_qc  = r_qc[AW-1];
    assign o_qr  = r_qr[AW-1];

endmodule

// ===== rtl/cka_grid.sv =====
// Grid key table memory with fill count, lookup, append and clear.
module cka_grid #(
    parameter int GRID_COLUMNS = 4,
    parameter int GRID_ROWS    = 4,
    parameter int AW           = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  cka_pkg::t_ctl   i_ctl,
    input  cka_pkg::t_rgb   i_pix,
    input  logic            i_ovf,
    input  logic [AW-1:0]   i_qc,
    input  logic [AW-1:0]   i_qr,
    output logic            o_valid,
    output logic            o_hit,
    output cka_pkg::t_rgb   o_pix,
    output cka_pkg::t_rgb   o_key
);
    localparam int Depth = GRID_COLUMNS * GRID_ROWS;
    localparam int CW    = $clog2(Depth + 1);
    localparam int IW    = AW + 6;

    cka_pkg::t_rgb r_mem [Depth];
    cka_pkg::t_rgb r_rd;
    cka_pkg::t_rgb r_pix;
    logic [CW-1:0] r_cnt;
    logic          r_v;
    logic          r_hit;

    logic [IW-1:0] w_idx;
    logic          w_hit;
    logic          w_load;
    logic          w_clear;

    assign w_idx   = IW'(i_qr) * IW'(GRID_COLUMNS) + IW'(i_qc);
    assign w_hit   = !i_ovf && (w_idx < IW'(r_cnt));
    assign w_load  = i_en && i_ctl.valid && (i_ctl.req == cka_pkg::REQ_LOAD)
                  && (r_cnt < CW'(Depth));
    assign w_clear = i_en && i_ctl.valid && (i_ctl.req == cka_pkg::REQ_CLEAR);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[r_cnt[AW-1:0]] <= i_pix;
        end
        if (i_en) begin
            r_rd <= r_mem[w_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v   <= 1'b0;
        end else begin
            if (w_clear) begin
                r_cnt <= '0;
            end else if (w_load) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_en) begin
                r_v   <= i_ctl.valid && (i_ctl.req == cka_pkg::REQ_PIXEL);
                r_hit <= w_hit;
                r_pix <= i_pix;
            end
        end
    end

    assign o_valid = r_v;
    assign o_hit   = r_hit;
    assign o_pix   = r_pix;
    assign o_key   = r_rd;

endmodule

// ===== rtl/cka_sat.sv =====
// Key select, primary channel, saturation products and alpha classification.
module cka_sat (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_hit,
    input  cka_pkg::t_rgb                 i_pix,
    input  cka_pkg::t_rgb                 i_key,
    input  cka_pkg::t_rgb                 i_def,
    input  logic [8:0]                    i_balance,
    output logic                          o_valid,
    output cka_pkg::t_cls                 o_cls,
    output logic [cka_pkg::NumW-1:0]      o_num,
    output logic [cka_pkg::DenW-1:0]      o_den
);
    function automatic logic [15:0] mix(input logic [8:0] bal, input logic [7:0] lo,
                                        input logic [7:0] hi);
        logic [16:0] m_lo;
        logic [16:0] m_hi;
        logic [16:0] sum;
        m_lo = bal * lo;
        m_hi = (cka_pkg::BAL_ONE - bal) * hi;
        sum  = m_lo + m_hi;
        return sum[15:0];
    endfunction

    function automatic logic signed [33:0] sat(input logic [7:0] cp, input logic [15:0] v);
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic signed [33:0] r;
        a = $signed({1'b0, cp, 8'b0}) - $signed({1'b0, v});
        b = $signed({1'b0, cka_pkg::UNIT_V - v});
        r = a * b;
        return r;
    endfunction

    cka_pkg::t_rgb w_key;
    logic [1:0]    w_p;
    logic [7:0]    w_pcp, w_plo, w_phi, w_kcp, w_klo, w_khi;

    logic          r1_v;
    logic [7:0]    r1_pcp, r1_kcp;
    logic [15:0]   r1_pv, r1_kv;

    logic               r2_v;
    logic signed [33:0] r2_s, r2_ks;

    logic                        r3_v;
    cka_pkg::t_cls               r3_cls;
    logic [cka_pkg::NumW-1:0]    r3_num;
    logic [cka_pkg::DenW-1:0]    r3_den;

    cka_pkg::t_cls               w_cls;
    logic signed [33:0]          w_diff;
    logic [cka_pkg::NumW-1:0]    w_d40;

    always_comb begin
        w_key = i_hit ? i_key : i_def;
        if (w_key.red > w_key.green) begin
            w_p = (w_key.red > w_key.blue) ? cka_pkg::CH_RED : cka_pkg::CH_BLUE;
        end else begin
            w_p = (w_key.green > w_key.blue) ? cka_pkg::CH_GREEN : cka_pkg::CH_BLUE;
        end
        case (w_p)
            cka_pkg::CH_RED: begin
                w_pcp = i_pix.red;   w_plo = i_pix.green; w_phi = i_pix.blue;
                w_kcp = w_key.red;   w_klo = w_key.green; w_khi = w_key.blue;
            end
            cka_pkg::CH_GREEN: begin
                w_pcp = i_pix.green; w_plo = i_pix.red;   w_phi = i_pix.blue;
                w_kcp = w_key.green; w_klo = w_key.red;   w_khi = w_key.blue;
            end
            default: begin
                w_pcp = i_pix.blue;  w_plo = i_pix.red;   w_phi = i_pix.green;
                w_kcp = w_key.blue;  w_klo = w_key.red;   w_khi = w_key.green;
            end
        endcase
    end

    always_comb begin
        w_diff = r2_ks - r2_s;
        w_d40  = cka_pkg::NumW'(w_diff[31:0]);
        if (r2_s < 0) begin
            w_cls = cka_pkg::CLS_FG;
        end else if (r2_s >= r2_ks) begin
            w_cls = cka_pkg::CLS_BG;
        end else begin
            w_cls = cka_pkg::CLS_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v   <= i_valid;
            r1_pcp <= w_pcp;
            r1_kcp <= w_kcp;
            r1_pv  <= mix(i_balance, w_plo, w_phi);
            r1_kv  <= mix(i_balance, w_klo, w_khi);
            r2_v   <= r1_v;
            r2_s   <= sat(r1_pcp, r1_pv);
            r2_ks  <= sat(r1_kcp, r1_kv);
            r3_v   <= r2_v;
            r3_cls <= w_cls;
            r3_num <= (w_d40 << 8) - w_d40;
            r3_den <= r2_ks[31:0];
        end
    end

    assign o_valid = r3_v;
    assign o_cls   = r3_cls;
    assign o_num   = r3_num;
    assign o_den   = r3_den;

endmodule

// ===== rtl/cka_adiv.sv =====
// Pipelined restoring divide that forms the alpha quotient.
module cka_adiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  cka_pkg::t_cls                 i_cls,
    input  logic [cka_pkg::NumW-1:0]      i_num,
    input  logic [cka_pkg::DenW-1:0]      i_den,
    output logic                          o_valid,
    output logic [cka_pkg::AlphaW-1:0]    o_alpha
);
    localparam int QW = cka_pkg::AlphaW;
    localparam int NW = cka_pkg::NumW;
    localparam int DW = cka_pkg::DenW;

    logic          r_v   [QW];
    cka_pkg::t_cls r_cls [QW];
    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        localparam int K = QW - 1 - s;
        logic          a_v;
        cka_pkg::t_cls a_cls;
        logic [NW-1:0] a_rem;
        logic [DW-1:0] a_den;
        logic [QW-1:0] a_q;
        logic [NW-1:0] d;
        logic          t;

        if (s == 0) begin : g_head
            assign a_v   = i_valid;
            assign a_cls = i_cls;
            assign a_rem = i_num;
            assign a_den = i_den;
            assign a_q   = '0;
        end else begin : g_body
            assign a_v   = r_v[s-1];
            assign a_cls = r_cls[s-1];
            assign a_rem = r_rem[s-1];
            assign a_den = r_den[s-1];
            assign a_q   = r_q[s-1];
        end

        assign d = NW'(a_den) << K;
        assign t = a_rem >= d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s]   <= a_v;
                r_cls[s] <= a_cls;
                r_rem[s] <= t ? (a_rem - d) : a_rem;
                r_den[s] <= a_den;
                r_q[s]   <= a_q | (QW'(t) << K);
            end
        end
    end

    always_comb begin
        case (r_cls[QW-1])
            cka_pkg::CLS_FG: o_alpha = cka_pkg::ALPHA_FG;
            cka_pkg::CLS_BG: o_alpha = cka_pkg::ALPHA_BG;
            default:         o_alpha = r_q[QW-1];
        endcase
    end

    assign o_valid = r_v[QW-1];

endmodule

// ===== rtl/chroma_key_alpha_matte.sv =====
// Chroma key alpha matte top level: config registers, pipeline and output skid.
// Pipeline: clog2(GRID_COLUMNS*GRID_ROWS) block divide stages, 1 table read, 3 saturation
// stages, 8 alpha divide stages and 1 output register.
// Throughput: one item per clock; ready drops only while the output skid register is full.
// Reset (synchronous, active low) clears pipeline valids and the table fill count, sets the
// configuration registers to their defaults; the table contents stay undefined until loaded.
module chroma_key_alpha_matte #(
    parameter int GRID_COLUMNS = 4,
    parameter int GRID_ROWS    = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cka_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [cka_pkg::CfgW-1:0]       i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_blue,
    input  logic [15:0]                    i_column,
    input  logic [15:0]                    i_line,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_alpha
);
    localparam int Depth = GRID_COLUMNS * GRID_ROWS;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

    logic [8:0]    r_balance;
    cka_pkg::t_rgb r_def;
    logic [15:0]   r_bw;
    logic [15:0]   r_bh;

    logic          w_en;
    cka_pkg::t_ctl w_in_ctl;
    cka_pkg::t_rgb w_in_pix;
    logic [15:0]   w_bw, w_bh;

    cka_pkg::t_ctl d_ctl;
    cka_pkg::t_rgb d_pix;
    logic          d_ovf;
    logic [AW-1:0] d_qc, d_qr;

    logic          g_v, g_hit;
    cka_pkg::t_rgb g_pix, g_key;

    logic                       s_v;
    cka_pkg::t_cls              s_cls;
    logic [cka_pkg::NumW-1:0]   s_num;
    logic [cka_pkg::DenW-1:0]   s_den;

    logic       w_pv;
    logic [7:0] w_pa;

    logic       r_out_v, r_skid_v;
    logic [7:0] r_out_alpha, r_skid_alpha;

    assign w_en     = !r_skid_v;
    assign o_ready  = w_en;
    assign w_in_ctl = '{valid: i_valid, req: cka_pkg::t_req'(i_req_type)};
    assign w_in_pix = '{red: i_red, green: i_green, blue: i_blue};
    assign w_bw     = (r_bw == 16'd0) ? 16'd1 : r_bw;
    assign w_bh     = (r_bh == 16'd0) ? 16'd1 : r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balance <= 9'd128;
            r_def     <= '{red: 8'd0, green: 8'd255, blue: 8'd0};
            r_bw      <= 16'd480;
            r_bh      <= 16'd270;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cka_pkg::CFG_BALANCE:
                    r_balance <= (i_cfg_data[8:0] > cka_pkg::BAL_ONE) ? cka_pkg::BAL_ONE
                                                                      : i_cfg_data[8:0];
                cka_pkg::CFG_KEY_RED:      r_def.red   <= i_cfg_data[7:0];
                cka_pkg::CFG_KEY_GREEN:    r_def.green <= i_cfg_data[7:0];
                cka_pkg::CFG_KEY_BLUE:     r_def.blue  <= i_cfg_data[7:0];
                cka_pkg::CFG_BLOCK_WIDTH:  r_bw        <= i_cfg_data;
                cka_pkg::CFG_BLOCK_HEIGHT: r_bh        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cka_blkdiv #(.AW(AW)) u_blkdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_in_ctl),
        .i_pix    (w_in_pix),
        .i_column (i_column),
        .i_line   (i_line),
        .i_bw     (w_bw),
        .i_bh     (w_bh),
        .o_ctl    (d_ctl),
        .o_pix    (d_pix),
        .o_ovf    (d_ovf),
        .o_qc     (d_qc),
        .o_qr     (d_qr)
    );

    cka_grid #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS),
        .AW           (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (d_ctl),
        .i_pix   (d_pix),
        .i_ovf   (d_ovf),
        .i_qc    (d_qc),
        .i_qr    (d_qr),
        .o_valid (g_v),
        .o_hit   (g_hit),
        .o_pix   (g_pix),
        .o_key   (g_key)
    );

    cka_sat u_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (g_v),
        .i_hit     (g_hit),
        .i_pix     (g_pix),
        .i_key     (g_key),
        .i_def     (r_def),
        .i_balance (r_balance),
        .o_valid   (s_v),
        .o_cls     (s_cls),
        .o_num     (s_num),
        .o_den     (s_den)
    );

    cka_adiv u_adiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_v),
        .i_cls   (s_cls),
        .i_num   (s_num),
        .i_den   (s_den),
        .o_valid (w_pv),
        .o_alpha (w_pa)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_out_alpha <= r_skid_alpha;
                r_skid_v    <= 1'b0;
            end
        end else if (!r_out_v || i_ready) begin
            r_out_v     <= w_pv;
            r_out_alpha <= w_pa;
        end else if (w_pv) begin
            r_skid_v     <= 1'b1;
            r_skid_alpha <= w_pa;
        end
    end

    assign o_valid = r_out_v;
    assign o_alpha = r_out_alpha;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds an item while output is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> (r_out_v && $stable(r_out_alpha)))
        else $error("stalled output item changed");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_ready) |=> (r_skid_v && $stable(r_skid_alpha)))
        else $error("stalled skid item changed");

endmodule
